### src/okl_pkg.sv
// Package for the ordered key list: mode, kind and status codes, cell
// operation codes and the control bundle broadcast along the cell row.
// No dependencies.
`default_nettype none

package okl_pkg;

  // Default list depth
  localparam int DEPTH_DEF = 64;

  // Command modes
  localparam logic [2:0] MODE_INS   = 3'd0;
  localparam logic [2:0] MODE_DELK  = 3'd1;
  localparam logic [2:0] MODE_DELF  = 3'd2;
  localparam logic [2:0] MODE_DELB  = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_STAT  = 2'd0;
  localparam logic [1:0] KIND_ELEM  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NOFIND  = 2'd3;

  // What every cell does in a cycle
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,   // keep key
    OP_PUSH = 3'd1,   // take key from the front-side neighbour
    OP_PULL = 3'd2,   // take key from the back-side neighbour
    OP_DROP = 3'd3,   // pull only at and behind the first matching cell
    OP_ROT  = 3'd4    // pull, tail cell takes the head key
  } cell_op_t;

  // Broadcast to all cells
  typedef struct packed {
    cell_op_t    op;
    logic [31:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

### src/okl_cell.sv
// One storage cell of the ordered key list: a key register, an occupancy
// compare against the list length and the first-match chain link.
// Depends on okl_pkg.
`default_nettype none

module okl_cell
  import okl_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [31:0]      left_key,
  input  wire logic [31:0]      right_key,
  input  wire logic [31:0]      head_key,
  input  wire logic             hit_in,
  output logic                  hit_out,
  output logic [31:0]           key_q
);

  logic occupied;
  logic is_tail;
  logic match;

  // Position against the current list length
  assign occupied = count > CNT_W'(IDX);
  assign is_tail  = count == CNT_W'(IDX + 1);

  // First-match chain: once a match is seen, every cell behind it collapses
  assign match   = occupied && (key_q == ctl.key);
  assign hit_out = hit_in | match;

  // Key register
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_PUSH: key_q <= left_key;
      OP_PULL: key_q <= right_key;
      OP_DROP: begin
        if (hit_out) begin
          key_q <= right_key;
        end
      end
      OP_ROT:  key_q <= is_tail ? head_key : right_key;
      default: key_q <= key_q;
    endcase
  end

endmodule

`default_nettype wire

### src/ordered_key_list_with_delete.sv
// Top level of the ordered key list: command decode, list length, read-out
// sequencing and the row of okl_cell storage cells.
// Depends on okl_pkg and okl_cell.
//
//  channel   | handshake          | fields
//  ----------+--------------------+---------------------------
//  command   | start / busy       | mode, key
//  result    | strobe (one cycle) | kind, value, status, last
//
// Insert and the deletes never raise busy: a command accepted at one edge has
// its result on the ports in the next cycle, so commands may follow one another
// every cycle. A read out holds busy from the accepting edge while the cell row
// rotates every entry past the head cell; its elements follow one per cycle, the
// first once the read-out flag and then the result registers have been loaded.
// An empty read out gives its single result in the cycle after start.
// Reset (rst, synchronous) empties the list. Results cannot be stalled.
`default_nettype none

module ordered_key_list_with_delete
  import okl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         mode,
  input  wire logic signed [31:0] key,
  output logic                    strobe,
  output logic [1:0]              kind,
  output logic signed [31:0]      value,
  output logic [1:0]              status,
  output logic                    last
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] remaining;
  logic             reading;
  logic             empty;
  logic             full;
  logic             found;
  cell_ctl_t        ctl;
  logic [31:0]      keys [DEPTH];
  logic [DEPTH:0]   hits;

  assign accept = start && !busy;
  assign busy   = reading;
  assign empty  = count == '0;
  assign full   = count >= CNT_W'(DEPTH);
  assign found  = hits[DEPTH];

  // Cell operation for this cycle
  always_comb begin
    ctl.key = key;
    ctl.op  = OP_HOLD;
    if (reading) begin
      ctl.op = OP_ROT;
    end else if (accept) begin
      unique case (mode)
        MODE_INS:  if (!full)  ctl.op = OP_PUSH;
        MODE_DELK: if (!empty) ctl.op = OP_DROP;
        MODE_DELF: if (!empty) ctl.op = OP_PULL;
        default:   ctl.op = OP_HOLD;
      endcase
    end
  end

  // List length
  always_comb begin
    count_next = count;
    if (accept) begin
      unique case (mode) inside
        MODE_INS:  if (!full) count_next = count + CNT_W'(1);
        MODE_DELK: if (!empty && found) count_next = count - CNT_W'(1);
        MODE_DELF, MODE_DELB: if (!empty) count_next = count - CNT_W'(1);
        default:   count_next = count;
      endcase
    end
  end

  // Control registers; a non-empty read out gives no status item
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      reading   <= 1'b0;
      remaining <= '0;
      strobe    <= 1'b0;
    end else begin
      count  <= count_next;
      strobe <= (accept && !(mode == MODE_READ && !empty)) || reading;
      if (reading) begin
        remaining <= remaining - CNT_W'(1);
        if (remaining == CNT_W'(1)) begin
          reading <= 1'b0;
        end
      end else if (accept && mode == MODE_READ && !empty) begin
        reading   <= 1'b1;
        remaining <= count;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (reading) begin
      kind   <= KIND_ELEM;
      value  <= keys[0];
      status <= ST_DONE;
      last   <= remaining == CNT_W'(1);
    end else begin
      kind   <= KIND_STAT;
      value  <= '0;
      status <= ST_DONE;
      last   <= 1'b1;
      unique case (mode) inside
        MODE_INS:  status <= full ? ST_FULL : ST_DONE;
        MODE_DELK: status <= empty ? ST_EMPTY : (found ? ST_DONE : ST_NOFIND);
        MODE_DELF, MODE_DELB: status <= empty ? ST_EMPTY : ST_DONE;
        MODE_READ: begin
          if (empty) begin
            kind   <= KIND_EMPTY;
            status <= ST_EMPTY;
          end
        end
        default:   status <= ST_DONE;
      endcase
    end
  end

  // Cell row
  assign hits[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_key;
    logic [31:0] right_key;

    if (i == 0) begin : g_head
      assign left_key = ctl.key;
    end else begin : g_mid
      assign left_key = keys[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_key = keys[i];
    end else begin : g_body
      assign right_key = keys[i+1];
    end

    okl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .left_key  (left_key),
      .right_key (right_key),
      .head_key  (keys[0]),
      .hit_in    (hits[i]),
      .hit_out   (hits[i+1]),
      .key_q     (keys[i])
    );
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("list length beyond depth");

  a_read_span: assert property (@(posedge clk) disable iff (rst)
    reading |-> (remaining != '0) && (remaining <= count))
    else $error("read-out counter out of range");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    accept && mode != MODE_READ |=> strobe && last && kind == KIND_STAT)
    else $error("command gave no status item");

  a_elem_source: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_ELEM |-> $past(reading))
    else $error("element item outside read out");

endmodule

`default_nettype wire

### tb/okl_checker.sv
`timescale 1ns / 1ps
// Checker for the ordered key list: watches the command and result ports, keeps
// its own copy of the list and compares every result with the oldest prediction.
// Depends on okl_pkg.
module okl_checker
  import okl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         mode,
  input  logic signed [31:0] key,
  input  logic               strobe,
  input  logic [1:0]         kind,
  input  logic signed [31:0] value,
  input  logic [1:0]         status,
  input  logic               last,
  output int                 fail_count,
  output int                 results_owed
);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } list_result_t;

  // Shadow list, front at index 0
  logic signed [31:0] shadow_keys [DEPTH];
  int                 shadow_len = 0;
  list_result_t       owed_q [$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  // Remove one entry and close the gap behind it
  task automatic remove_entry(input int pos);
    for (int i = pos; i + 1 < shadow_len; i++) shadow_keys[i] = shadow_keys[i + 1];
    shadow_len--;
  endtask

  // Apply one command to the shadow list and queue the results it gives
  task automatic run_list_command(input logic [2:0] m, input logic signed [31:0] k);
    list_result_t res;
    int           hit;
    res = '{kind: KIND_STAT, value: '0, status: ST_DONE, last: 1'b1};
    case (m)
      MODE_INS: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > 0; i--) shadow_keys[i] = shadow_keys[i - 1];
          shadow_keys[0] = k;
          shadow_len++;
        end
      end
      MODE_DELK: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < shadow_len; i++)
            if (hit < 0 && shadow_keys[i] == k) hit = i;
          if (hit < 0) res.status = ST_NOFIND;
          else remove_entry(hit);
        end
      end
      MODE_DELF: begin
        if (shadow_len == 0) res.status = ST_EMPTY;
        else remove_entry(0);
      end
      MODE_DELB: begin
        if (shadow_len == 0) res.status = ST_EMPTY;
        else shadow_len--;
      end
      MODE_READ: begin
        if (shadow_len == 0) begin
          res.kind   = KIND_EMPTY;
          res.status = ST_EMPTY;
        end else begin
          // one element per entry, front to back; the last one carries the marker
          for (int i = 0; i < shadow_len; i++) begin
            res.kind  = KIND_ELEM;
            res.value = shadow_keys[i];
            res.last  = (i + 1 == shadow_len);
            if (i + 1 < shadow_len) owed_q.push_back(res);
          end
        end
      end
      default: ;  // unused codes: plain done status
    endcase
    owed_q.push_back(res);
  endtask

  // Results are compared before new commands are predicted
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst) begin
      shadow_len = 0;
      owed_q.delete();
    end else begin
      if (strobe) begin
        got = '{kind: kind, value: value, status: status, last: last};
        if (owed_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: kind %0d value %0d status %0d last %0d",
                     got.kind, got.value, got.status, got.last);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.status !== want.status || got.last !== want.last) begin
            if (mismatches < 10)
              $display({"mismatch: expected kind %0d value %0d status %0d last %0d,",
                        " got kind %0d value %0d status %0d last %0d"},
                       want.kind, want.value, want.status, want.last,
                       got.kind, got.value, got.status, got.last);
            mismatches++;
          end
        end
      end
      if (start && !busy) run_list_command(mode, key);
    end
    results_owed <= owed_q.size();
  end

endmodule

### tb/tb_ordered_key_list_with_delete.sv
`timescale 1ns / 1ps
// Testbench top for the ordered key list: clock, reset, command stimulus and the
// verdict. Depends on okl_pkg, okl_checker and ordered_key_list_with_delete.
module tb_ordered_key_list_with_delete;
  import okl_pkg::*;

  localparam int                 RANDOM_ITEMS = 445;
  localparam int                 CALM_TAIL    = 60;
  localparam logic [2:0]         MODE_TOP     = 3'd7;
  localparam logic signed [31:0] KEY_MAX      = 32'sh7fffffff;
  localparam logic signed [31:0] KEY_MIN      = 32'sh80000000;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         mode  = MODE_INS;
  logic signed [31:0] key   = '0;
  logic               busy;
  logic               strobe;
  logic [1:0]         kind;
  logic signed [31:0] value;
  logic [1:0]         status;
  logic               last;
  int                 fail_count;
  int                 results_owed;

  always #10 clk = ~clk;

  ordered_key_list_with_delete dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .mode   (mode),
    .key    (key),
    .strobe (strobe),
    .kind   (kind),
    .value  (value),
    .status (status),
    .last   (last)
  );

  okl_checker #(.DEPTH(DEPTH_DEF)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .key          (key),
    .strobe       (strobe),
    .kind         (kind),
    .value        (value),
    .status       (status),
    .last         (last),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // Present one command and hold it until an edge with busy low takes it
  task automatic send(input logic [2:0] m, input logic signed [31:0] k);
    start <= 1'b1;
    mode  <= m;
    key   <= k;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every predicted result has been seen
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  initial begin
    int                 r;
    logic [2:0]         m;
    logic signed [31:0] k;
    bit                 growing;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list cases, extreme keys, duplicates, every mode
    send(MODE_READ, 0);
    send(MODE_DELK, 5);
    send(MODE_DELF, 0);
    send(MODE_DELB, 0);
    send(MODE_INS, KEY_MAX);
    send(MODE_INS, KEY_MIN);
    send(MODE_INS, 0);
    send(MODE_INS, -1);
    send(MODE_INS, 5);
    send(MODE_INS, 5);
    send(MODE_READ, 0);
    send(MODE_DELK, 5);
    send(MODE_DELK, 1234);
    send(MODE_DELK, KEY_MIN);
    send(MODE_READ, 0);
    send(MODE_DELF, 0);
    send(MODE_DELB, 0);
    send(MODE_READ, 0);
    send(MODE_READ + 3'd1, KEY_MAX);
    send(MODE_READ + 3'd2, -1);
    send(MODE_TOP, KEY_MIN);
    send(MODE_DELF, 0);
    send(MODE_DELB, 0);
    send(MODE_READ, 0);
    wait_drained();

    // Random: alternate growing and shrinking phases so the list reaches full
    // and empty; keys drawn mostly from a small pool so deletes find matches
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      growing = ((i / 110) % 2) == 0;
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
        idle($urandom_range(1, 3));
      r = $urandom_range(0, 99);
      if (growing) begin
        if (r < 80)      m = MODE_INS;
        else if (r < 84) m = MODE_DELK;
        else if (r < 87) m = MODE_DELF;
        else if (r < 90) m = MODE_DELB;
        else if (r < 96) m = MODE_READ;
        else             m = 3'($urandom_range(MODE_READ + 3'd1, MODE_TOP));
      end else begin
        if (r < 8)       m = MODE_INS;
        else if (r < 36) m = MODE_DELK;
        else if (r < 60) m = MODE_DELF;
        else if (r < 86) m = MODE_DELB;
        else if (r < 95) m = MODE_READ;
        else             m = 3'($urandom_range(MODE_READ + 3'd1, MODE_TOP));
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
        k = $urandom_range(0, 7);
      end else if (r < 6) begin
        case ($urandom_range(0, 3))
          0:       k = KEY_MAX;
          1:       k = KEY_MIN;
          2:       k = 0;
          default: k = -1;
        endcase
      end else begin
        k = $urandom;
      end
      send(m, k);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
